// ----- rtl/core/lpl_pkg.sv -----
package lpl_pkg;

    // Default table size and key length.
    localparam int LPL_ENTRIES       = 4096;
    localparam int LPL_MAX_KEY_CHARS = 20;

    // Fixed widths of the port fields.
    localparam int CFG_W     = 13;
    localparam int IN_CHARS  = 20;
    localparam int IN_IDX_W  = 12;
    localparam int STR_LEN_W = 5;
    localparam int IDX_OUT_W = 12;
    localparam int LEN_OUT_W = 5;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREFIX,
        S_PROBE,
        S_COMPARE,
        S_DONE
    } t_state;

    // Outcome of comparing a stored key with a query prefix.
    typedef struct packed {
        logic bytes_lt;
        logic bytes_gt;
        logic key_shorter;
        logic key_longer;
    } t_cmp;

endpackage

// ----- rtl/core/lpl_ram.sv -----
module lpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = lpl_pkg::LPL_ENTRIES,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/lpl_key_prep.sv -----
module lpl_key_prep #(
    parameter int MAX_KEY_CHARS = lpl_pkg::LPL_MAX_KEY_CHARS,
    localparam int LW           = $clog2(MAX_KEY_CHARS + 1),
    localparam int KW           = MAX_KEY_CHARS * 8
) (
    input  logic [63:0]                   i_chars_0_to_7,
    input  logic [63:0]                   i_chars_8_to_15,
    input  logic [31:0]                   i_chars_16_to_19,
    input  logic [lpl_pkg::STR_LEN_W-1:0] i_string_length,
    output logic [KW-1:0]                 o_chars,
    output logic [LW-1:0]                 o_length
);

    localparam int INW = lpl_pkg::IN_CHARS * 8;

    logic [INW-1:0] w_raw;
    logic [LW-1:0]  w_limit;

    assign w_raw = {i_chars_16_to_19, i_chars_8_to_15, i_chars_0_to_7};

    // Characters beyond the input fields read as zero.
    for (genvar k = 0; k < MAX_KEY_CHARS; k++) begin : g_char
        if (k < lpl_pkg::IN_CHARS) begin : g_in
            assign o_chars[k*8 +: 8] = w_raw[k*8 +: 8];
        end else begin : g_zero
            assign o_chars[k*8 +: 8] = 8'h00;
        end
    end

    always_comb begin
        if (32'(i_string_length) > MAX_KEY_CHARS) begin
            w_limit = LW'(MAX_KEY_CHARS);
        end else begin
            w_limit = LW'(i_string_length);
        end
    end

    // The effective length stops at the first zero byte below the limit.
    always_comb begin
        o_length = w_limit;
        for (int k = MAX_KEY_CHARS - 1; k >= 0; k--) begin
            if (k < int'(w_limit) && o_chars[k*8 +: 8] == 8'h00) begin
                o_length = LW'(k);
            end
        end
    end

endmodule

// ----- rtl/core/lpl_key_cmp.sv -----
module lpl_key_cmp #(
    parameter int MAX_KEY_CHARS = lpl_pkg::LPL_MAX_KEY_CHARS,
    localparam int LW           = $clog2(MAX_KEY_CHARS + 1),
    localparam int KW           = MAX_KEY_CHARS * 8
) (
    input  logic [KW-1:0]     i_key_chars,
    input  logic [LW-1:0]     i_key_length,
    input  logic [KW-1:0]     i_query_chars,
    input  logic [LW-1:0]     i_prefix_length,
    output lpl_pkg::t_cmp     o_cmp
);

    logic [LW-1:0] w_common;
    logic [KW-1:0] w_key_be;
    logic [KW-1:0] w_query_be;

    assign w_common = (i_key_length < i_prefix_length) ? i_key_length : i_prefix_length;

    // Both strings are cut to the common length and laid out with the first
    // character most significant, so that string order becomes a plain
    // magnitude compare.
    for (genvar k = 0; k < MAX_KEY_CHARS; k++) begin : g_be
        assign w_key_be[(MAX_KEY_CHARS-1-k)*8 +: 8] =
            (k < w_common) ? i_key_chars[k*8 +: 8] : 8'h00;
        assign w_query_be[(MAX_KEY_CHARS-1-k)*8 +: 8] =
            (k < w_common) ? i_query_chars[k*8 +: 8] : 8'h00;
    end

    always_comb begin
        o_cmp.bytes_lt    = w_key_be < w_query_be;
        o_cmp.bytes_gt    = w_key_be > w_query_be;
        o_cmp.key_shorter = i_key_length < i_prefix_length;
        o_cmp.key_longer  = i_key_length > i_prefix_length;
    end

endmodule

// ----- rtl/core/longest_prefix_lookup_core.sv -----
// Channel   Handshake            Contents
// -------   ------------------   ---------------------------------------------
// command   start / busy         i_operation, i_entry_index, i_chars_*, i_string_length
// config    i_cfg_we             i_cfg_wdata (entry_count)
// result    o_valid (strobe)     o_found, o_match_index, o_match_length
//
// A write does not make the block busy: the key goes into the table at the edge that
// accepts it. A lookup of effective length L keeps busy high while it runs one binary
// search of the key table for each prefix length from 1 up to L, of at most 13 probes
// for 4096 entries, each probe being one read of the key table and one compare.
// The result strobe comes in the last busy cycle. Reset is
// synchronous and leaves the table contents undefined; the receiver cannot stall.
module longest_prefix_lookup_core #(
    parameter int ENTRIES       = lpl_pkg::LPL_ENTRIES,
    parameter int MAX_KEY_CHARS = lpl_pkg::LPL_MAX_KEY_CHARS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [lpl_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_operation,
    input  logic [lpl_pkg::IN_IDX_W-1:0]  i_entry_index,
    input  logic [63:0]                   i_chars_0_to_7,
    input  logic [63:0]                   i_chars_8_to_15,
    input  logic [31:0]                   i_chars_16_to_19,
    input  logic [lpl_pkg::STR_LEN_W-1:0] i_string_length,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [lpl_pkg::IDX_OUT_W-1:0] o_match_index,
    output logic [lpl_pkg::LEN_OUT_W-1:0] o_match_length
);

    localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW  = $clog2(ENTRIES + 1);
    localparam int LW  = $clog2(MAX_KEY_CHARS + 1);
    localparam int PW  = $clog2(MAX_KEY_CHARS + 2);
    localparam int KW  = MAX_KEY_CHARS * 8;
    localparam int RW  = KW + LW;
    localparam int OIW = lpl_pkg::IDX_OUT_W;
    localparam int OLW = lpl_pkg::LEN_OUT_W;

    lpl_pkg::t_state r_state, n_state;

    logic [lpl_pkg::CFG_W-1:0] r_entry_count;
    logic [CW-1:0]             w_count;

    logic [KW-1:0] w_in_chars;
    logic [LW-1:0] w_in_len;
    logic [KW-1:0] r_q_chars;
    logic [LW-1:0] r_q_len;

    logic [PW-1:0] r_p, n_p;
    logic [CW-1:0] r_low, n_low;
    logic [CW-1:0] r_hiex, n_hiex;
    logic [CW-1:0] r_olow, n_olow;
    logic [CW-1:0] r_ohiex, n_ohiex;
    logic [IW-1:0] r_mid, n_mid;
    logic [CW:0]   w_mid_sum;
    logic [IW-1:0] w_mid;

    logic          r_found, n_found;
    logic [IW-1:0] r_hit_idx, n_hit_idx;
    logic [LW-1:0] r_hit_len, n_hit_len;

    logic          w_accept;
    logic          w_lookup;
    logic          w_write;
    logic [RW-1:0] w_rdata;
    lpl_pkg::t_cmp w_cmp;
    logic          w_hit;
    logic          w_below;

    assign w_accept = start && !busy;
    assign w_lookup = w_accept && (i_operation == lpl_pkg::OP_LOOKUP);
    assign w_write  = w_accept && (i_operation == lpl_pkg::OP_WRITE)
                      && (32'(i_entry_index) < ENTRIES);

    always_comb begin
        if (32'(r_entry_count) > ENTRIES) begin
            w_count = CW'(ENTRIES);
        end else begin
            w_count = CW'(r_entry_count);
        end
    end

    // Bounds are held as [low, hiex) so that an empty range needs no sign.
    assign w_mid_sum = (CW+1)'(r_low) + (CW+1)'(r_hiex) - (CW+1)'(1);
    assign w_mid     = IW'(w_mid_sum >> 1);

    lpl_key_prep #(
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_prep (
        .i_chars_0_to_7   (i_chars_0_to_7),
        .i_chars_8_to_15  (i_chars_8_to_15),
        .i_chars_16_to_19 (i_chars_16_to_19),
        .i_string_length  (i_string_length),
        .o_chars          (w_in_chars),
        .o_length         (w_in_len)
    );

    lpl_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_write),
        .i_waddr (IW'(i_entry_index)),
        .i_wdata ({w_in_len, w_in_chars}),
        .i_raddr (w_mid),
        .o_rdata (w_rdata)
    );

    lpl_key_cmp #(
        .MAX_KEY_CHARS (MAX_KEY_CHARS)
    ) u_cmp (
        .i_key_chars     (w_rdata[KW-1:0]),
        .i_key_length    (w_rdata[RW-1:KW]),
        .i_query_chars   (r_q_chars),
        .i_prefix_length (LW'(r_p)),
        .o_cmp           (w_cmp)
    );

    assign w_hit   = !w_cmp.bytes_lt && !w_cmp.bytes_gt
                     && !w_cmp.key_shorter && !w_cmp.key_longer;
    assign w_below = w_cmp.bytes_lt || (!w_cmp.bytes_gt && w_cmp.key_shorter);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lpl_pkg::S_IDLE: begin
                if (w_lookup) begin
                    n_state = lpl_pkg::S_PREFIX;
                end
            end
            lpl_pkg::S_PREFIX: begin
                if (r_p > PW'(r_q_len)) begin
                    n_state = lpl_pkg::S_DONE;
                end else begin
                    n_state = lpl_pkg::S_PROBE;
                end
            end
            lpl_pkg::S_PROBE: begin
                if (r_low < r_hiex) begin
                    n_state = lpl_pkg::S_COMPARE;
                end else begin
                    n_state = lpl_pkg::S_PREFIX;
                end
            end
            lpl_pkg::S_COMPARE: begin
                if (w_hit) begin
                    n_state = lpl_pkg::S_PREFIX;
                end else begin
                    n_state = lpl_pkg::S_PROBE;
                end
            end
            lpl_pkg::S_DONE: begin
                n_state = lpl_pkg::S_IDLE;
            end
            default: begin
                n_state = lpl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_p       = r_p;
        n_low     = r_low;
        n_hiex    = r_hiex;
        n_olow    = r_olow;
        n_ohiex   = r_ohiex;
        n_mid     = r_mid;
        n_found   = r_found;
        n_hit_idx = r_hit_idx;
        n_hit_len = r_hit_len;
        unique case (r_state)
            lpl_pkg::S_IDLE: begin
                if (w_lookup) begin
                    n_p       = PW'(1);
                    n_olow    = '0;
                    n_ohiex   = w_count;
                    n_found   = 1'b0;
                    n_hit_idx = '0;
                    n_hit_len = '0;
                end
            end
            lpl_pkg::S_PREFIX: begin
                n_low  = r_olow;
                n_hiex = r_ohiex;
            end
            lpl_pkg::S_PROBE: begin
                if (r_low < r_hiex) begin
                    n_mid = w_mid;
                end else begin
                    n_p = r_p + PW'(1);
                end
            end
            lpl_pkg::S_COMPARE: begin
                if (w_hit) begin
                    n_found   = 1'b1;
                    n_hit_idx = r_mid;
                    n_hit_len = LW'(r_p);
                    n_p       = r_p + PW'(1);
                end else if (w_below) begin
                    // The truncated key also sorts below, so the outer bound moves too.
                    n_low  = CW'(r_mid) + CW'(1);
                    n_olow = CW'(r_mid) + CW'(1);
                end else begin
                    n_hiex = CW'(r_mid);
                    // A key that merely extends the prefix leaves the outer bound alone.
                    if (w_cmp.bytes_gt) begin
                        n_ohiex = CW'(r_mid);
                    end
                end
            end
            lpl_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        busy           = (r_state != lpl_pkg::S_IDLE);
        o_valid        = (r_state == lpl_pkg::S_DONE);
        o_found        = r_found;
        o_match_index  = OIW'(r_hit_idx);
        o_match_length = OLW'(r_hit_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lpl_pkg::S_IDLE;
            r_entry_count <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lookup) begin
            r_q_chars <= w_in_chars;
            r_q_len   <= w_in_len;
        end
        r_p       <= n_p;
        r_low     <= n_low;
        r_hiex    <= n_hiex;
        r_olow    <= n_olow;
        r_ohiex   <= n_ohiex;
        r_mid     <= n_mid;
        r_found   <= n_found;
        r_hit_idx <= n_hit_idx;
        r_hit_len <= n_hit_len;
    end

endmodule

// ----- rtl/core/lpl_checker.sv -----
module lpl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_cfg_we,
    input logic [lpl_pkg::CFG_W-1:0]     i_cfg_wdata,
    input logic                          i_operation,
    input logic [lpl_pkg::IN_IDX_W-1:0]  i_entry_index,
    input logic [63:0]                   i_chars_0_to_7,
    input logic [63:0]                   i_chars_8_to_15,
    input logic [31:0]                   i_chars_16_to_19,
    input logic [lpl_pkg::STR_LEN_W-1:0] i_string_length,
    input logic                          o_valid,
    input logic                          o_found,
    input logic [lpl_pkg::IDX_OUT_W-1:0] o_match_index,
    input logic [lpl_pkg::LEN_OUT_W-1:0] o_match_length
);

    // A result only ever closes a lookup that is still holding the block.
    a_valid_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a busy lookup");

    // One transfer per lookup, after which the block is free again.
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid && !busy)
        else $error("result strobe not followed by idle");

    // A write is absorbed at the edge that accepts it.
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_operation == lpl_pkg::OP_WRITE) |=> !busy)
        else $error("write transfer made the block busy");

    // A miss reports zero fields; a hit matches at least one character.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_match_index == '0) && (o_match_length == '0))
        else $error("miss with non-zero match fields");

    a_hit_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> (o_match_length != '0))
        else $error("hit with zero match length");

endmodule

bind longest_prefix_lookup_core lpl_checker u_lpl_checker (.*);

// ----- dv/tb.sv -----
module tb;

    import lpl_pkg::*;

    localparam int MAX_CHARS      = LPL_MAX_KEY_CHARS;
    localparam int KEY_BITS       = IN_CHARS * 8;
    localparam int SETTLE_CYCLES  = 4;
    // Covers the longest lookup, with some margin.
    localparam int TAIL_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        t_op                  op;
        logic [IN_IDX_W-1:0]  idx;
        logic [KEY_BITS-1:0]  chars;
        logic [STR_LEN_W-1:0] slen;
    } t_lookup_cmd;

    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] index;
        logic [LEN_OUT_W-1:0] length;
    } t_match;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic                 o_valid;
    logic                 o_found;
    logic [IDX_OUT_W-1:0] o_match_index;
    logic [LEN_OUT_W-1:0] o_match_length;
    t_lookup_cmd          cur_cmd = '0;

    // Mirror of the key table and of the entry count register.
    logic [KEY_BITS-1:0]  key_store [LPL_ENTRIES];
    logic [4:0]           key_len [LPL_ENTRIES];
    int                   entry_limit = 0;

    t_lookup_cmd          pending_cmds[$];
    t_match               expected_matches[$];
    int                   cmds_queued = 0;
    int                   cmds_accepted = 0;
    int                   sender_idle_pct = 0;
    int                   n_fail = 0;
    int                   quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    longest_prefix_lookup_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_operation      (cur_cmd.op),
        .i_entry_index    (cur_cmd.idx),
        .i_chars_0_to_7   (cur_cmd.chars[63:0]),
        .i_chars_8_to_15  (cur_cmd.chars[127:64]),
        .i_chars_16_to_19 (cur_cmd.chars[159:128]),
        .i_string_length  (cur_cmd.slen),
        .o_valid          (o_valid),
        .o_found          (o_found),
        .o_match_index    (o_match_index),
        .o_match_length   (o_match_length)
    );

    function automatic logic [KEY_BITS-1:0] random_bits();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [7:0] alpha_char();
        return 8'h61 + 8'($urandom_range(3, 0));
    endfunction

    function automatic logic [KEY_BITS-1:0] text_bytes(string txt);
        logic [KEY_BITS-1:0] s;
        int k;
        s = '0;
        for (k = 0; k < txt.len() && k < MAX_CHARS; k++) s[8*k +: 8] = txt[k];
        return s;
    endfunction

    // Length as the block sees it: cut at the first zero byte and at MAX_CHARS.
    function automatic int eff_len(logic [KEY_BITS-1:0] s, logic [4:0] slen);
        int lim;
        int k;
        lim = slen > MAX_CHARS ? MAX_CHARS : slen;
        for (k = 0; k < lim; k++) if (s[8*k +: 8] == 8'h00) return k;
        return lim;
    endfunction

    function automatic int order_of(logic [KEY_BITS-1:0] a, int alen,
                                    logic [KEY_BITS-1:0] b, int blen);
        int k;
        for (k = 0; k < alen && k < blen; k++) begin
            if (a[8*k +: 8] < b[8*k +: 8]) return -1;
            if (a[8*k +: 8] > b[8*k +: 8]) return 1;
        end
        if (alen < blen) return -1;
        if (alen > blen) return 1;
        return 0;
    endfunction

    function automatic t_match longest_match(t_lookup_cmd q);
        t_match r;
        int qlen, count, lo_out, hi_out, lo, hi, mid, klen, tlen, d, p;
        logic hit;
        r = '0;
        qlen = eff_len(q.chars, q.slen);
        count = entry_limit > LPL_ENTRIES ? LPL_ENTRIES : entry_limit;
        lo_out = 0;
        hi_out = count - 1;
        for (p = 1; p <= qlen; p++) begin
            lo = lo_out;
            hi = hi_out;
            hit = 1'b0;
            while (lo <= hi && !hit) begin
                mid = (lo + hi) / 2;
                klen = key_len[mid];
                d = order_of(key_store[mid], klen, q.chars, p);
                if (d == 0) begin
                    hit = 1'b1;
                    r.found = 1'b1;
                    r.index = mid;
                    r.length = p;
                end else begin
                    if (d < 0) lo = mid + 1;
                    else hi = mid - 1;
                    // The probed key cut to p characters narrows the bounds for longer prefixes.
                    tlen = klen < p ? klen : p;
                    d = order_of(key_store[mid], tlen, q.chars, p);
                    if (d < 0) lo_out = mid + 1;
                    else if (d > 0) hi_out = mid - 1;
                end
            end
        end
        return r;
    endfunction

    function automatic void apply_cmd(t_lookup_cmd c);
        if (c.op == OP_WRITE) begin
            key_store[c.idx] = c.chars;
            key_len[c.idx] = eff_len(c.chars, c.slen);
        end else begin
            expected_matches.push_back(longest_match(c));
        end
        cmds_accepted++;
    endfunction

    function automatic t_lookup_cmd make_cmd(t_op op, logic [IN_IDX_W-1:0] idx,
                                             logic [KEY_BITS-1:0] chars,
                                             logic [STR_LEN_W-1:0] slen);
        t_lookup_cmd c;
        c.op = op;
        c.idx = idx;
        c.chars = chars;
        c.slen = slen;
        return c;
    endfunction

    // Bytes past the string are filled with noise; the end is marked either by
    // the length field alone or by a zero byte under a longer length field.
    function automatic t_lookup_cmd encode_cmd(t_op op, logic [IN_IDX_W-1:0] idx,
                                               logic [KEY_BITS-1:0] s, int n);
        logic [KEY_BITS-1:0] noise;
        logic [STR_LEN_W-1:0] slen;
        int k;
        noise = random_bits();
        for (k = n; k < MAX_CHARS; k++) s[8*k +: 8] = noise[8*k +: 8];
        slen = n;
        if (n < MAX_CHARS && $urandom_range(1, 0) == 1) begin
            s[8*n +: 8] = 8'h00;
            slen = $urandom_range(31, n);
        end else if (n == MAX_CHARS) begin
            slen = $urandom_range(31, MAX_CHARS);
        end
        return make_cmd(op, idx, s, slen);
    endfunction

    // Produces a key that sorts strictly after the given one, mostly by
    // extending it or bumping one of its last characters.
    function automatic void next_key(inout logic [KEY_BITS-1:0] s, inout int n);
        int c, tail, k;
        logic done;
        done = 1'b0;
        while (!done) begin
            if ($urandom_range(3, 0) != 0) c = $urandom_range(n, n > 2 ? n - 2 : 0);
            else c = $urandom_range(n, 0);
            if (c == n) begin
                if (n < MAX_CHARS) begin
                    tail = $urandom_range(MAX_CHARS - n < 3 ? MAX_CHARS - n : 3, 1);
                    for (k = n; k < n + tail; k++) s[8*k +: 8] = alpha_char();
                    n = n + tail;
                    done = 1'b1;
                end
            end else if (s[8*c +: 8] != 8'hff) begin
                if (s[8*c +: 8] == 8'hfe) s[8*c +: 8] = 8'hff;
                else s[8*c +: 8] = s[8*c +: 8] + 8'($urandom_range(2, 1));
                n = c + 1;
                tail = $urandom_range(MAX_CHARS - n < 3 ? MAX_CHARS - n : 3, 0);
                for (k = n; k < n + tail; k++) s[8*k +: 8] = alpha_char();
                n = n + tail;
                done = 1'b1;
            end
        end
    endfunction

    function automatic void queue_cmd(t_lookup_cmd c);
        pending_cmds.push_back(c);
        cmds_queued++;
    endfunction

    function automatic void queue_sorted_table(int size);
        logic [KEY_BITS-1:0] s;
        int n, k, i;
        s = '0;
        n = $urandom_range(3, 0);
        for (k = 0; k < n; k++) s[8*k +: 8] = alpha_char();
        for (i = 0; i < size; i++) begin
            queue_cmd(encode_cmd(OP_WRITE, i, s, n));
            next_key(s, n);
        end
    endfunction

    // Most queries grow out of a loaded key so that prefixes hit at many depths.
    function automatic t_lookup_cmd random_query(int count);
        logic [KEY_BITS-1:0] s;
        int sel, n, keep, k, pos;
        sel = $urandom_range(99, 0);
        s = '0;
        if (sel >= 85)
            return make_cmd(OP_LOOKUP, $urandom_range(4095, 0), random_bits(),
                            $urandom_range(31, 0));
        if (count > 0 && sel < 65) begin
            k = $urandom_range(count - 1, 0);
            s = key_store[k];
            n = key_len[k];
            keep = $urandom_range(1, 0) == 1 ? n : $urandom_range(n, 0);
            n = keep + $urandom_range(MAX_CHARS - keep < 4 ? MAX_CHARS - keep : 4, 0);
            for (k = keep; k < n; k++) s[8*k +: 8] = alpha_char();
            if (n > 0 && $urandom_range(4, 0) == 0) begin
                pos = $urandom_range(n - 1, 0);
                s[8*pos +: 8] = $urandom_range(8'h66, 8'h60);
            end
        end else begin
            n = $urandom_range(MAX_CHARS, 0);
            for (k = 0; k < n; k++) s[8*k +: 8] = alpha_char();
        end
        return encode_cmd(OP_LOOKUP, $urandom_range(4095, 0), s, n);
    endfunction

    task automatic wait_drained();
        do @(posedge i_clk);
        while (cmds_accepted != cmds_queued || expected_matches.size() != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_entry_count(int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        entry_limit = value;
    endtask

    task automatic run_phase(int idle_pct, int table_size, int count, int lookups);
        int k;
        sender_idle_pct = idle_pct;
        if (table_size > 0) begin
            queue_sorted_table(table_size);
            wait_drained();
        end
        write_entry_count(count);
        for (k = 0; k < lookups; k++) queue_cmd(random_query(count));
        wait_drained();
    endtask

    always @(posedge i_clk) begin : cmd_driver
        logic send;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) apply_cmd(cur_cmd);
            if (!start || !busy) begin
                send = pending_cmds.size() != 0 &&
                       $urandom_range(99, 0) >= sender_idle_pct;
                if (send) cur_cmd <= pending_cmds.pop_front();
                start <= send;
            end
        end
    end

    function automatic void report_mismatch(string field, logic [11:0] want,
                                            logic [11:0] got);
        n_fail++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    always @(posedge i_clk) begin : result_monitor
        t_match want;
        if (i_rst_n && o_valid) begin
            if (expected_matches.size() == 0) begin
                n_fail++;
                $display("%0t: unexpected result, expected none, actual %0b/%0h/%0d",
                         $time, o_found, o_match_index, o_match_length);
            end else begin
                want = expected_matches.pop_front();
                if (o_found !== want.found) report_mismatch("found", want.found, o_found);
                if (o_match_index !== want.index)
                    report_mismatch("match_index", want.index, o_match_index);
                if (o_match_length !== want.length)
                    report_mismatch("match_length", want.length, o_match_length);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && !busy) || o_valid || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("longest_prefix_lookup_core test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [KEY_BITS-1:0] s;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hand-made table: empty key, nested prefixes, a zero-terminated key,
        // an over-long length field and full-length keys of top byte values.
        sender_idle_pct = 34;
        queue_cmd(make_cmd(OP_WRITE, 0, random_bits(), 0));
        queue_cmd(make_cmd(OP_WRITE, 1, text_bytes("a"), 1));
        queue_cmd(make_cmd(OP_WRITE, 2, text_bytes("ab"), 2));
        queue_cmd(make_cmd(OP_WRITE, 3, text_bytes("abc"), 31));
        queue_cmd(make_cmd(OP_WRITE, 4, text_bytes("abd"), 3));
        queue_cmd(make_cmd(OP_WRITE, 5, text_bytes("b"), 1));
        queue_cmd(make_cmd(OP_WRITE, 6, {20{8'h62}}, 25));
        queue_cmd(make_cmd(OP_WRITE, '1, '1, 20));
        queue_cmd(make_cmd(OP_WRITE, 7, '1, 20));
        wait_drained();
        write_entry_count(0);
        queue_cmd(make_cmd(OP_LOOKUP, '1, text_bytes("abc"), 3));
        wait_drained();
        write_entry_count(8);
        queue_cmd(make_cmd(OP_LOOKUP, 0, text_bytes("abcz"), 4));
        queue_cmd(make_cmd(OP_LOOKUP, 0, text_bytes("abd"), 3));
        queue_cmd(make_cmd(OP_LOOKUP, 0, text_bytes("x"), 1));
        queue_cmd(make_cmd(OP_LOOKUP, 0, text_bytes("ab"), 0));
        s = text_bytes("abzc");
        s[23:16] = 8'h00;
        queue_cmd(make_cmd(OP_LOOKUP, 0, s, 4));
        queue_cmd(make_cmd(OP_LOOKUP, 0, {20{8'h62}}, 31));
        queue_cmd(make_cmd(OP_LOOKUP, 0, '1, 20));
        queue_cmd(make_cmd(OP_LOOKUP, 0, {{19{8'h63}}, 8'h61}, 1));
        queue_cmd(make_cmd(OP_LOOKUP, 0, text_bytes("ba"), 2));
        wait_drained();

        run_phase(34, 1, 1, 20);
        run_phase(34, 24, 24, 80);
        run_phase(80, 0, 0, 10);
        run_phase(80, 400, 400, 120);
        run_phase(0, 0, 2, 30);
        run_phase(0, 0, 300, 50);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("longest_prefix_lookup_core test passed");
        end else begin
            $display("longest_prefix_lookup_core test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lpl_pkg.sv
rtl/core/lpl_ram.sv
rtl/core/lpl_key_prep.sv
rtl/core/lpl_key_cmp.sv
rtl/core/longest_prefix_lookup_core.sv
rtl/core/lpl_checker.sv
dv/tb.sv
